// ----- sv/lin_sfh_pkg.sv -----
`default_nettype none

package lin_sfh_pkg;

    localparam logic [2:0] OP_RX_BYTE    = 3'd0;
    localparam logic [2:0] OP_BREAK      = 3'd1;
    localparam logic [2:0] OP_TX_FREE    = 3'd2;
    localparam logic [2:0] OP_LINE_ERROR = 3'd3;
    localparam logic [2:0] OP_TEMP       = 3'd4;

    localparam logic [2:0] REG_PID_GET_TEMP   = 3'd0;
    localparam logic [2:0] REG_PID_GET_CONFIG = 3'd1;
    localparam logic [2:0] REG_PID_SET_CONFIG = 3'd2;
    localparam logic [2:0] REG_NODE_ID        = 3'd3;
    localparam logic [2:0] REG_OFFSET_MV      = 3'd4;
    localparam logic [2:0] REG_GAIN_BITS      = 3'd5;
    localparam logic [2:0] REG_FILTER_MODES   = 3'd6;
    localparam logic [2:0] REG_FACTORY_SERIAL = 3'd7;

    localparam logic [7:0] SYNC_BYTE     = 8'h55;
    localparam logic [4:0] TEMP_TX_LEN   = 5'd3;
    localparam logic [4:0] CFG_TX_LEN    = 5'd20;
    localparam logic [4:0] CFG_RX_LEN    = 5'd16;
    localparam logic [4:0] CFG_PAYLOAD   = 5'd15;
    localparam int         TX_DEPTH      = 20;
    localparam int         RX_DEPTH      = 16;
    localparam int         PAYLOAD_W     = 120;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_AWAIT,
        PH_PID,
        PH_DATA
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TXRD,
        ST_BUILD,
        ST_RXSUM,
        ST_PUSH
    } state_t;

    typedef struct packed {
        logic [7:0]  pid_get_temp;
        logic [7:0]  pid_get_config;
        logic [7:0]  pid_set_config;
        logic [31:0] node_id;
        logic [15:0] offset_mv;
        logic [31:0] gain_bits;
        logic [15:0] filter_modes;
        logic [31:0] factory_serial;
    } cfg_regs_t;

    typedef struct packed {
        logic       load;
        logic       add;
        logic [7:0] operand;
    } csum_ctl_t;

    // byte of the configuration response, little-endian fields
    function automatic logic [7:0] cfg_resp_byte(cfg_regs_t c, logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = c.node_id[7:0];
            5'd1:    b = c.node_id[15:8];
            5'd2:    b = c.node_id[23:16];
            5'd3:    b = c.node_id[31:24];
            5'd4:    b = c.offset_mv[7:0];
            5'd5:    b = c.offset_mv[15:8];
            5'd6:    b = c.gain_bits[7:0];
            5'd7:    b = c.gain_bits[15:8];
            5'd8:    b = c.gain_bits[23:16];
            5'd9:    b = c.gain_bits[31:24];
            5'd10:   b = c.pid_get_temp;
            5'd11:   b = c.pid_get_config;
            5'd12:   b = c.pid_set_config;
            5'd13:   b = c.filter_modes[7:0];
            5'd14:   b = c.filter_modes[15:8];
            5'd15:   b = c.factory_serial[7:0];
            5'd16:   b = c.factory_serial[15:8];
            5'd17:   b = c.factory_serial[23:16];
            5'd18:   b = c.factory_serial[31:24];
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lin_sfh_ram.sv -----
`default_nettype none

module lin_sfh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire logic [WIDTH-1:0]           wdata,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr,
    output logic      [WIDTH-1:0]           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/lin_sfh_csum.sv -----
`default_nettype none

module lin_sfh_csum
    import lin_sfh_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire csum_ctl_t  ctl,
    output logic [7:0]      acc,
    output logic [7:0]      sum
);

    logic [7:0] acc_reg;
    logic [7:0] acc_next;
    logic [8:0] raw;

    // add with end-around carry
    assign raw = {1'b0, acc_reg} + {1'b0, ctl.operand};
    assign sum = raw[8] ? (raw[7:0] + 8'd1) : raw[7:0];
    assign acc = acc_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
        begin
            acc_next = ctl.operand;
        end
        else if (ctl.add)
        begin
            acc_next = sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= 8'h00;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lin_sfh_cfg.sv -----
`default_nettype none

module lin_sfh_cfg
    import lin_sfh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [31:0] wr_data,
    output cfg_regs_t        regs
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_PID_GET_TEMP:   cfg_next.pid_get_temp   = wr_data[7:0];
                REG_PID_GET_CONFIG: cfg_next.pid_get_config = wr_data[7:0];
                REG_PID_SET_CONFIG: cfg_next.pid_set_config = wr_data[7:0];
                REG_NODE_ID:        cfg_next.node_id        = wr_data;
                REG_OFFSET_MV:      cfg_next.offset_mv      = wr_data[15:0];
                REG_GAIN_BITS:      cfg_next.gain_bits      = wr_data;
                REG_FILTER_MODES:   cfg_next.filter_modes   = wr_data[15:0];
                REG_FACTORY_SERIAL: cfg_next.factory_serial = wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pid_get_temp   <= 8'd16;
            cfg_reg.pid_get_config <= 8'd17;
            cfg_reg.pid_set_config <= 8'd18;
            cfg_reg.node_id        <= 32'd0;
            cfg_reg.offset_mv      <= 16'd0;
            cfg_reg.gain_bits      <= 32'd0;
            cfg_reg.filter_modes   <= 16'd0;
            cfg_reg.factory_serial <= 32'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign regs = cfg_reg;

endmodule

`default_nettype wire

// ----- sv/lin_slave_frame_handler.sv -----
// transmit slot free: the next response byte is read from the transmit store and pushed
// temperature or config pid: the response is built into the transmit store before its first
// byte is pushed, one checksum adder step per data byte; 16th byte of a config write: result
// only on a checksum match; every other item is handled while idle; not ready while the sequencer is busy
// a finished result waits in the output register while the next item is taken
// reset: control state and config registers to defaults, byte stores undefined
`default_nettype none

module lin_slave_frame_handler
    import lin_sfh_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         operation,
    input  wire logic [7:0]         rx_byte,
    input  wire logic signed [15:0] temperature,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    kind,
    output logic [7:0]              tx_byte,
    output logic [31:0]             new_node_id,
    output logic [15:0]             new_offset_mv,
    output logic [31:0]             new_gain_bits,
    output logic [7:0]              new_pid_get_temp,
    output logic [7:0]              new_pid_get_config,
    output logic [7:0]              new_pid_set_config,
    output logic [15:0]             new_filter_modes,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data
);

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [4:0]           rx_count_reg, rx_count_next;
    logic [7:0]           active_pid_reg, active_pid_next;
    logic [4:0]           tx_pos_reg, tx_pos_next;
    logic [4:0]           tx_len_reg, tx_len_next;
    logic [15:0]          temp_reg, temp_next;
    logic [4:0]           idx_reg, idx_next;
    logic [4:0]           build_last_reg, build_last_next;
    logic                 build_cfg_reg, build_cfg_next;
    logic                 res_kind_reg, res_kind_next;
    logic [7:0]           res_byte_reg, res_byte_next;
    logic [7:0]           last_byte_reg, last_byte_next;
    logic [PAYLOAD_W-1:0] payload_reg, payload_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg;
    logic [7:0]           out_byte_reg;
    logic [PAYLOAD_W-1:0] out_payload_reg;

    cfg_regs_t            cfg;
    csum_ctl_t            csum_ctl;
    logic [7:0]           csum_acc;
    logic [7:0]           csum_sum;

    logic                 in_fire;
    logic                 is_byte;
    logic                 pid_temp_hit;
    logic                 pid_cfg_hit;
    logic                 pid_set_hit;
    logic                 start_build;
    logic                 start_rxsum;
    logic                 start_txrd;
    logic                 push_fire;
    logic                 rx_match;
    logic [4:0]           rx_count_inc;
    logic [7:0]           build_src;

    logic                 tx_we;
    logic [7:0]           tx_wdata;
    logic [7:0]           tx_rdata;
    logic                 rx_we;
    logic [7:0]           rx_rdata;

    lin_sfh_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .regs     (cfg)
    );

    lin_sfh_csum u_csum (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (csum_ctl),
        .acc   (csum_acc),
        .sum   (csum_sum)
    );

    lin_sfh_ram #(.WIDTH(8), .DEPTH(TX_DEPTH)) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (idx_reg),
        .wdata (tx_wdata),
        .raddr (tx_pos_reg),
        .rdata (tx_rdata)
    );

    lin_sfh_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_count_reg[3:0]),
        .wdata (rx_byte),
        .raddr (idx_reg[3:0]),
        .rdata (rx_rdata)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid & in_ready;
    assign is_byte   = in_fire && (operation == OP_RX_BYTE);

    // pid compare order decides: temperature, get-config, set-config
    assign pid_temp_hit = (rx_byte == cfg.pid_get_temp);
    assign pid_cfg_hit  = !pid_temp_hit && (rx_byte == cfg.pid_get_config);
    assign pid_set_hit  = !pid_temp_hit && !pid_cfg_hit && (rx_byte == cfg.pid_set_config);

    assign rx_count_inc = rx_count_reg + 5'd1;
    assign start_build  = is_byte && (phase_reg == PH_PID) && (pid_temp_hit || pid_cfg_hit);
    assign start_rxsum  = is_byte && (phase_reg == PH_DATA) && (rx_count_inc == CFG_RX_LEN);
    assign start_txrd   = in_fire && (operation == OP_TX_FREE) && (tx_len_reg != 5'd0)
                          && (tx_pos_reg < tx_len_reg);
    assign push_fire    = (state_reg == ST_PUSH) && (!out_valid_reg || out_ready);
    assign rx_match     = ~csum_sum == last_byte_reg;

    assign build_src = build_cfg_reg ? cfg_resp_byte(cfg, idx_reg)
                                     : (idx_reg[0] ? temp_reg[15:8] : temp_reg[7:0]);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                priority if (start_build)
                    state_next = ST_BUILD;
                else if (start_rxsum)
                    state_next = ST_RXSUM;
                else if (start_txrd)
                    state_next = ST_TXRD;
            end
            ST_TXRD:
                state_next = ST_PUSH;
            ST_BUILD:
            begin
                if (idx_reg == build_last_reg)
                    state_next = ST_PUSH;
            end
            ST_RXSUM:
            begin
                if (idx_reg == CFG_PAYLOAD)
                    state_next = rx_match ? ST_PUSH : ST_IDLE;
            end
            ST_PUSH:
            begin
                if (push_fire)
                    state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and sequencer outputs
    always_comb
    begin
        phase_next      = phase_reg;
        rx_count_next   = rx_count_reg;
        active_pid_next = active_pid_reg;
        tx_pos_next     = tx_pos_reg;
        tx_len_next     = tx_len_reg;
        temp_next       = temp_reg;
        idx_next        = idx_reg;
        build_last_next = build_last_reg;
        build_cfg_next  = build_cfg_reg;
        res_kind_next   = res_kind_reg;
        res_byte_next   = res_byte_reg;
        last_byte_next  = last_byte_reg;
        payload_next    = payload_reg;
        csum_ctl        = '{load: 1'b0, add: 1'b0, operand: 8'h00};
        tx_we           = 1'b0;
        tx_wdata        = build_src;
        rx_we           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (operation)
                        OP_RX_BYTE:
                        begin
                            unique case (phase_reg)
                                PH_AWAIT:
                                    phase_next = (rx_byte == SYNC_BYTE) ? PH_PID : PH_IDLE;
                                PH_PID:
                                begin
                                    phase_next = PH_IDLE;
                                    if (pid_temp_hit || pid_cfg_hit)
                                    begin
                                        csum_ctl = '{load: 1'b1, add: 1'b0, operand: rx_byte};
                                        idx_next        = 5'd0;
                                        build_cfg_next  = pid_cfg_hit;
                                        build_last_next = pid_cfg_hit ? (CFG_TX_LEN - 5'd1)
                                                                      : (TEMP_TX_LEN - 5'd1);
                                        res_byte_next   = pid_cfg_hit ? cfg.node_id[7:0]
                                                                      : temp_reg[7:0];
                                        tx_pos_next     = 5'd1;
                                        tx_len_next     = pid_cfg_hit ? CFG_TX_LEN : TEMP_TX_LEN;
                                    end
                                    else if (pid_set_hit)
                                    begin
                                        phase_next      = PH_DATA;
                                        rx_count_next   = 5'd0;
                                        active_pid_next = rx_byte;
                                    end
                                end
                                PH_DATA:
                                begin
                                    rx_we         = 1'b1;
                                    rx_count_next = rx_count_inc;
                                    if (start_rxsum)
                                    begin
                                        phase_next     = PH_IDLE;
                                        csum_ctl = '{load: 1'b1, add: 1'b0,
                                                     operand: active_pid_reg};
                                        last_byte_next = rx_byte;
                                        idx_next       = 5'd0;
                                    end
                                end
                                PH_IDLE:
                                begin
                                end
                            endcase
                        end
                        OP_BREAK:
                        begin
                            phase_next      = PH_AWAIT;
                            rx_count_next   = 5'd0;
                            active_pid_next = 8'h00;
                        end
                        OP_TX_FREE:
                        begin
                            if (start_txrd)
                            begin
                                tx_pos_next = tx_pos_reg + 5'd1;
                            end
                            else if (tx_len_reg != 5'd0)
                            begin
                                // end of response
                                phase_next      = PH_IDLE;
                                rx_count_next   = 5'd0;
                                active_pid_next = 8'h00;
                                tx_len_next     = 5'd0;
                            end
                        end
                        OP_LINE_ERROR:
                        begin
                            phase_next      = PH_IDLE;
                            rx_count_next   = 5'd0;
                            active_pid_next = 8'h00;
                        end
                        OP_TEMP:
                            temp_next = $unsigned(temperature);
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TXRD:
            begin
                res_kind_next = 1'b0;
                res_byte_next = tx_rdata;
            end
            ST_BUILD:
            begin
                tx_we = 1'b1;
                if (idx_reg == build_last_reg)
                begin
                    tx_wdata      = ~csum_acc;
                    res_kind_next = 1'b0;
                end
                else
                begin
                    csum_ctl = '{load: 1'b0, add: 1'b1, operand: build_src};
                    idx_next = idx_reg + 5'd1;
                end
            end
            ST_RXSUM:
            begin
                // read of byte n is issued at step n, consumed at step n+1
                if (idx_reg != 5'd0)
                begin
                    csum_ctl     = '{load: 1'b0, add: 1'b1, operand: rx_rdata};
                    payload_next = {rx_rdata, payload_reg[PAYLOAD_W-1:8]};
                end
                if (idx_reg != CFG_PAYLOAD)
                begin
                    idx_next = idx_reg + 5'd1;
                end
                res_kind_next = 1'b1;
                res_byte_next = 8'h00;
            end
            ST_PUSH:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (push_fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            rx_count_reg   <= 5'd0;
            active_pid_reg <= 8'h00;
            tx_pos_reg     <= 5'd0;
            tx_len_reg     <= 5'd0;
            temp_reg       <= 16'd0;
            idx_reg        <= 5'd0;
            build_last_reg <= 5'd0;
            build_cfg_reg  <= 1'b0;
            res_kind_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            rx_count_reg   <= rx_count_next;
            active_pid_reg <= active_pid_next;
            tx_pos_reg     <= tx_pos_next;
            tx_len_reg     <= tx_len_next;
            temp_reg       <= temp_next;
            idx_reg        <= idx_next;
            build_last_reg <= build_last_next;
            build_cfg_reg  <= build_cfg_next;
            res_kind_reg   <= res_kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_byte_reg  <= res_byte_next;
        last_byte_reg <= last_byte_next;
        payload_reg   <= payload_next;
        if (push_fire)
        begin
            out_kind_reg    <= res_kind_reg;
            out_byte_reg    <= res_byte_reg;
            out_payload_reg <= payload_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign kind               = out_kind_reg;
    assign tx_byte            = out_kind_reg ? 8'h00 : out_byte_reg;
    assign new_node_id        = out_kind_reg ? out_payload_reg[31:0]    : 32'd0;
    assign new_offset_mv      = out_kind_reg ? out_payload_reg[47:32]   : 16'd0;
    assign new_gain_bits      = out_kind_reg ? out_payload_reg[79:48]   : 32'd0;
    assign new_pid_get_temp   = out_kind_reg ? out_payload_reg[87:80]   : 8'h00;
    assign new_pid_get_config = out_kind_reg ? out_payload_reg[95:88]   : 8'h00;
    assign new_pid_set_config = out_kind_reg ? out_payload_reg[103:96]  : 8'h00;
    assign new_filter_modes   = out_kind_reg ? out_payload_reg[119:104] : 16'd0;

`ifndef SYNTHESIS
    a_tx_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_len_reg == 5'd0) || (tx_len_reg == TEMP_TX_LEN) || (tx_len_reg == CFG_TX_LEN))
        else $error("response length out of range");

    a_tx_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_len_reg != 5'd0) |-> (tx_pos_reg <= tx_len_reg))
        else $error("transmit position past response end");

    a_rx_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (rx_count_reg < CFG_RX_LEN))
        else $error("receive count overran frame");

    a_build_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BUILD) |-> (idx_reg <= build_last_reg))
        else $error("response build index past end");

    a_cfg_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RXSUM) && (idx_reg == CFG_PAYLOAD) && rx_match
        |=> (state_reg == ST_PUSH) && res_kind_reg && (phase_reg == PH_IDLE))
        else $error("config result not staged after checksum match");
`endif

endmodule

`default_nettype wire
